[rtl/fpc_pkg.sv]
// Shared types, constants and the CRC-32 byte step for the firmware package checker.
// No dependencies; the interfaces aside, every other file imports this package.
package fpc_pkg;

   localparam int unsigned MAX_BYTES_DEFAULT = 1048576;
   localparam int unsigned SLOTS_DEFAULT = 5;
   localparam int unsigned SIZE_W = 25;
   localparam int unsigned OFF_W = 33;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
   localparam int unsigned HDR_FIXED = 44;
   localparam int unsigned SLOT_STRIDE = 12;
   localparam int unsigned TRAILER_BYTES = 4;
   localparam int unsigned AUTH_SPAN = 6;

   localparam logic [2:0] REC_RGB = 3'd0;
   localparam logic [2:0] REC_DEPTH = 3'd1;
   localparam logic [2:0] REC_AUDIO = 3'd2;
   localparam logic [2:0] REC_SLOT0 = 3'd3;

   typedef struct packed {
      logic [SIZE_W-1:0] size;
      logic              crc_ok;
      logic              overflow;
   } job_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[rtl/fpc_req_if.sv]
// Byte channel into the checker: valid/ready handshake with one package byte.
// Depends on nothing.
interface fpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/fpc_rsp_if.sv]
// Record channel out of the checker: valid/ready handshake with one decoded record.
// Depends on nothing.
interface fpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  record_index;
   logic [15:0] ver_major;
   logic [15:0] ver_minor;
   logic [15:0] version_build;
   logic        pkg_ok;
   logic        crc_match;
   logic [7:0]  signature_kind;
   logic [7:0]  build_kind;
   logic [7:0]  certificate_kind;
   logic        certificate_found;
   logic [2:0]  depth_config_count;
   logic        last_record;

   modport source (output valid, output record_index, output ver_major,
                   output ver_minor, output version_build, output pkg_ok,
                   output crc_match, output signature_kind, output build_kind,
                   output certificate_kind, output certificate_found,
                   output depth_config_count, output last_record, input ready);
   modport sink (input valid, input record_index, input ver_major,
                 input ver_minor, input version_build, input pkg_ok,
                 input crc_match, input signature_kind, input build_kind,
                 input certificate_kind, input certificate_found,
                 input depth_config_count, input last_record, output ready);
endinterface

[rtl/fpc_store.sv]
// Package byte store: one write port for the front end, one registered read port.
// Depends on fpc_pkg.
module fpc_store
   import fpc_pkg::*;
#(
   parameter int unsigned MAX_PACKAGE_BYTES = MAX_BYTES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [$clog2(MAX_PACKAGE_BYTES)-1:0] wr_addr,
   input  logic [7:0]                           wr_data,
   input  logic                                 rd_en,
   input  logic [$clog2(MAX_PACKAGE_BYTES)-1:0] rd_addr,
   output logic [7:0]                           rd_data
);

   logic [7:0] mem [MAX_PACKAGE_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fpc_front.sv]
// Front end: accepts package bytes, writes the store, runs the CRC and trailer window.
// Depends on fpc_pkg and fpc_req_if; hands a job descriptor to the queue on the last byte.
module fpc_front
   import fpc_pkg::*;
#(
   parameter int unsigned MAX_PACKAGE_BYTES = MAX_BYTES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   fpc_req_if.sink                              req,
   input  logic                                 allow,
   output logic                                 wr_en,
   output logic [$clog2(MAX_PACKAGE_BYTES)-1:0] wr_addr,
   output logic [7:0]                           wr_data,
   output logic                                 job_push,
   output job_type                              job
);

   localparam int unsigned CNT_W = $clog2(MAX_PACKAGE_BYTES + 1);
   localparam int unsigned ADDR_W = $clog2(MAX_PACKAGE_BYTES);

   logic [CNT_W-1:0] count_ff, count_in, count_step;
   logic [31:0]      crc_ff, crc_in, crc_step;
   logic [31:0]      trailer_ff, trailer_in, trailer_step;
   logic             ovf_ff, ovf_in, ovf_step;
   logic             accept, room;

   assign req.ready = allow;
   assign accept = req.valid && allow;
   assign room = count_ff < CNT_W'(MAX_PACKAGE_BYTES);

   always_comb begin
      count_step = count_ff;
      crc_step = crc_ff;
      trailer_step = trailer_ff;
      ovf_step = ovf_ff;
      if (room) begin
         if (count_ff >= CNT_W'(TRAILER_BYTES)) begin
            crc_step = crc_byte(crc_ff, trailer_ff[7:0]);
         end
         trailer_step = {req.data_byte, trailer_ff[31:8]};
         count_step = count_ff + CNT_W'(1);
      end else begin
         ovf_step = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      crc_in = crc_ff;
      trailer_in = trailer_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req.last_byte) begin
            count_in = '0;
            crc_in = CRC_INIT;
            trailer_in = '0;
            ovf_in = 1'b0;
         end else begin
            count_in = count_step;
            crc_in = crc_step;
            trailer_in = trailer_step;
            ovf_in = ovf_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         crc_ff <= CRC_INIT;
         trailer_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         crc_ff <= crc_in;
         trailer_ff <= trailer_in;
         ovf_ff <= ovf_in;
      end
   end

   assign wr_en = accept && room;
   assign wr_addr = count_ff[ADDR_W-1:0];
   assign wr_data = req.data_byte;

   assign job_push = accept && req.last_byte;
   assign job.size = SIZE_W'(count_step);
   assign job.overflow = ovf_step;
   assign job.crc_ok = !ovf_step && (trailer_step == crc_step);

endmodule

[rtl/fpc_queue.sv]
// Two-entry job queue between the front end and the decoder.
// Depends on fpc_pkg.
module fpc_queue
   import fpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    not_empty,
   output job_type head
);

   job_type    slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign do_push = push && (fill_ff != 2'd2);
   assign do_pop = pop && (fill_ff != 2'd0);
   assign not_empty = fill_ff != 2'd0;
   assign head = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      fill_in = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule

[rtl/fpc_back.sv]
// Decoder: reads the stored package through the store read port, checks the header
// and certificate bounds, and emits the records. Depends on fpc_pkg and fpc_rsp_if.
module fpc_back
   import fpc_pkg::*;
#(
   parameter int unsigned MAX_PACKAGE_BYTES = MAX_BYTES_DEFAULT,
   parameter int unsigned DEPTH_CONFIG_SLOTS = SLOTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 job_valid,
   input  job_type                              job,
   output logic                                 job_pop,
   output logic                                 idle,
   output logic                                 rd_en,
   output logic [$clog2(MAX_PACKAGE_BYTES)-1:0] rd_addr,
   input  logic [7:0]                           rd_data,
   fpc_rsp_if.source                            rsp
);

   localparam int unsigned ADDR_W = $clog2(MAX_PACKAGE_BYTES);
   localparam int unsigned SLOT_W = $clog2(DEPTH_CONFIG_SLOTS + 1);
   localparam int unsigned HDR_BYTES = HDR_FIXED + SLOT_STRIDE * DEPTH_CONFIG_SLOTS;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_HDR = 4'd1;
   localparam logic [3:0] ST_AUTH = 4'd2;
   localparam logic [3:0] ST_CERT = 4'd3;
   localparam logic [3:0] ST_EMIT = 4'd4;
   localparam logic [3:0] ST_SLOT = 4'd5;
   localparam logic [3:0] ST_SLOT_EMIT = 4'd6;
   localparam logic [3:0] ST_SHORT = 4'd7;
   localparam logic [3:0] ST_DRAIN = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [5:0]        step_ff, step_in;
   logic              wait_ff, wait_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [1:0]        emit_ff, emit_in;
   logic              valid_ff, valid_in;
   logic              cert_ok_ff, cert_ok_in;
   logic              oob_ff;
   logic [SIZE_W-1:0] size_ff;
   logic              crc_ok_ff;

   logic [7:0]  sig_ff, bld_ff, ckind_ff;
   logic [31:0] auth_ff, coff_ff;
   logic [15:0] clen_ff, cnt_ff;
   logic [15:0] dmaj_ff, dmin_ff, dbld_ff;
   logic [15:0] rmaj_ff, rmin_ff, rbld_ff;
   logic [15:0] amaj_ff, amin_ff, abld_ff;
   logic [15:0] smaj_ff, smin_ff;

   logic [OFF_W-1:0] addr;
   logic             reading, oob, capture, last_step, out_free, load;
   logic [7:0]       rb;
   logic             cnt_bad;
   logic [15:0]      cnt_now, clen_now;
   logic [OFF_W-1:0] auth_end, cert_end;

   always_comb begin
      unique case (state_ff)
         ST_HDR:  addr = OFF_W'(step_ff);
         ST_AUTH: addr = {1'b0, auth_ff} + OFF_W'(step_ff);
         ST_CERT: addr = {1'b0, coff_ff};
         ST_SLOT: addr = OFF_W'(HDR_FIXED) + OFF_W'(slot_ff) * OFF_W'(SLOT_STRIDE)
                         + OFF_W'(step_ff);
         default: addr = '0;
      endcase
   end

   assign reading = (state_ff == ST_HDR) || (state_ff == ST_AUTH) ||
                    (state_ff == ST_CERT) || (state_ff == ST_SLOT);
   assign oob = addr >= OFF_W'(size_ff);
   assign rd_en = reading && !wait_ff;
   assign rd_addr = addr[ADDR_W-1:0];
   assign capture = reading && wait_ff;
   assign rb = oob_ff ? 8'd0 : rd_data;

   always_comb begin
      unique case (state_ff)
         ST_HDR:  last_step = step_ff == 6'(HDR_FIXED - 1);
         ST_AUTH: last_step = step_ff == 6'(AUTH_SPAN - 1);
         ST_SLOT: last_step = step_ff == 6'd3;
         default: last_step = 1'b1;
      endcase
   end

   assign out_free = !rsp.valid || rsp.ready;
   assign load = out_free && ((state_ff == ST_EMIT) || (state_ff == ST_SLOT_EMIT) ||
                              (state_ff == ST_SHORT));
   assign cnt_bad = cnt_ff > 16'(DEPTH_CONFIG_SLOTS);
   assign cnt_now = {rb, cnt_ff[7:0]};
   assign clen_now = {rb, clen_ff[7:0]};
   assign auth_end = {1'b0, auth_ff} + OFF_W'(AUTH_SPAN);
   assign cert_end = {1'b0, coff_ff} + OFF_W'(clen_now);

   assign idle = state_ff == ST_IDLE;
   assign job_pop = idle && job_valid;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      wait_in = wait_ff;
      slot_in = slot_ff;
      emit_in = emit_ff;
      valid_in = valid_ff;
      cert_ok_in = cert_ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               step_in = '0;
               wait_in = 1'b0;
               slot_in = '0;
               emit_in = '0;
               cert_ok_in = 1'b0;
               valid_in = job.crc_ok && !job.overflow;
               state_in = (job.size < SIZE_W'(HDR_BYTES)) ? ST_SHORT : ST_HDR;
            end
         end
         ST_HDR, ST_AUTH, ST_CERT, ST_SLOT: begin
            wait_in = !wait_ff;
            if (capture) begin
               step_in = step_ff + 6'd1;
               if (last_step) begin
                  step_in = '0;
                  unique case (state_ff)
                     ST_HDR: begin
                        if (cnt_now > 16'(DEPTH_CONFIG_SLOTS)) begin
                           valid_in = 1'b0;
                        end
                        if (auth_end > OFF_W'(size_ff)) begin
                           valid_in = 1'b0;
                           state_in = ST_EMIT;
                        end else begin
                           state_in = ST_AUTH;
                        end
                     end
                     ST_AUTH: begin
                        if (clen_now == 16'd0 || cert_end > OFF_W'(size_ff)) begin
                           valid_in = 1'b0;
                           state_in = ST_EMIT;
                        end else begin
                           cert_ok_in = 1'b1;
                           state_in = ST_CERT;
                        end
                     end
                     ST_CERT: state_in = ST_EMIT;
                     default: state_in = ST_SLOT_EMIT;
                  endcase
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit_in = emit_ff + 2'd1;
               if (emit_ff == 2'd2) begin
                  state_in = ST_SLOT;
               end
            end
         end
         ST_SLOT_EMIT: begin
            if (out_free) begin
               if (slot_ff == SLOT_W'(DEPTH_CONFIG_SLOTS - 1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  slot_in = slot_ff + SLOT_W'(1);
                  state_in = ST_SLOT;
               end
            end
         end
         ST_SHORT: begin
            if (out_free) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rsp.valid || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         wait_ff <= 1'b0;
         slot_ff <= '0;
         emit_ff <= '0;
         valid_ff <= 1'b0;
         cert_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         wait_ff <= wait_in;
         slot_ff <= slot_in;
         emit_ff <= emit_in;
         valid_ff <= valid_in;
         cert_ok_ff <= cert_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         size_ff <= job.size;
         crc_ok_ff <= job.crc_ok;
      end
      if (rd_en) begin
         oob_ff <= oob;
      end
      if (capture) begin
         unique case (state_ff)
            ST_HDR: begin
               case (step_ff)
                  6'd0:  sig_ff <= rb;
                  6'd1:  bld_ff <= rb;
                  6'd2:  auth_ff[7:0] <= rb;
                  6'd3:  auth_ff[15:8] <= rb;
                  6'd4:  auth_ff[23:16] <= rb;
                  6'd5:  auth_ff[31:24] <= rb;
                  6'd6:  dmaj_ff <= {8'd0, rb};
                  6'd7:  dmin_ff <= {8'd0, rb};
                  6'd8:  dbld_ff[7:0] <= rb;
                  6'd9:  dbld_ff[15:8] <= rb;
                  6'd18: rmaj_ff <= {8'd0, rb};
                  6'd19: rmin_ff <= {8'd0, rb};
                  6'd20: rbld_ff[7:0] <= rb;
                  6'd21: rbld_ff[15:8] <= rb;
                  6'd30: amaj_ff <= {8'd0, rb};
                  6'd31: amin_ff <= {8'd0, rb};
                  6'd32: abld_ff[7:0] <= rb;
                  6'd33: abld_ff[15:8] <= rb;
                  6'd42: cnt_ff[7:0] <= rb;
                  6'd43: cnt_ff[15:8] <= rb;
                  default: ;
               endcase
            end
            ST_AUTH: begin
               case (step_ff)
                  6'd0:    coff_ff[7:0] <= rb;
                  6'd1:    coff_ff[15:8] <= rb;
                  6'd2:    coff_ff[23:16] <= rb;
                  6'd3:    coff_ff[31:24] <= rb;
                  6'd4:    clen_ff[7:0] <= rb;
                  default: clen_ff[15:8] <= rb;
               endcase
            end
            ST_CERT: ckind_ff <= rb;
            default: begin
               case (step_ff)
                  6'd0:    smaj_ff[7:0] <= rb;
                  6'd1:    smaj_ff[15:8] <= rb;
                  6'd2:    smin_ff[7:0] <= rb;
                  default: smin_ff[15:8] <= rb;
               endcase
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp.valid <= 1'b0;
      end else if (load) begin
         rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
         rsp.valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (state_ff == ST_SHORT) begin
            rsp.record_index <= REC_RGB;
            rsp.ver_major <= '0;
            rsp.ver_minor <= '0;
            rsp.version_build <= '0;
            rsp.pkg_ok <= 1'b0;
            rsp.crc_match <= 1'b0;
            rsp.signature_kind <= '0;
            rsp.build_kind <= '0;
            rsp.certificate_kind <= '0;
            rsp.certificate_found <= 1'b0;
            rsp.depth_config_count <= '0;
            rsp.last_record <= 1'b1;
         end else begin
            rsp.pkg_ok <= valid_ff;
            rsp.crc_match <= crc_ok_ff;
            rsp.signature_kind <= sig_ff;
            rsp.build_kind <= bld_ff;
            rsp.certificate_kind <= cert_ok_ff ? ckind_ff : 8'd0;
            rsp.certificate_found <= cert_ok_ff;
            rsp.depth_config_count <= cnt_bad ? 3'd0 : cnt_ff[2:0];
            if (state_ff == ST_EMIT) begin
               rsp.last_record <= 1'b0;
               case (emit_ff)
                  2'd0: begin
                     rsp.record_index <= REC_RGB;
                     rsp.ver_major <= rmaj_ff;
                     rsp.ver_minor <= rmin_ff;
                     rsp.version_build <= rbld_ff;
                  end
                  2'd1: begin
                     rsp.record_index <= REC_DEPTH;
                     rsp.ver_major <= dmaj_ff;
                     rsp.ver_minor <= dmin_ff;
                     rsp.version_build <= dbld_ff;
                  end
                  default: begin
                     rsp.record_index <= REC_AUDIO;
                     rsp.ver_major <= amaj_ff;
                     rsp.ver_minor <= amin_ff;
                     rsp.version_build <= abld_ff;
                  end
               endcase
            end else begin
               rsp.record_index <= REC_SLOT0 + 3'(slot_ff);
               rsp.ver_major <= smaj_ff;
               rsp.ver_minor <= smin_ff;
               rsp.version_build <= '0;
               rsp.last_record <= slot_ff == SLOT_W'(DEPTH_CONFIG_SLOTS - 1);
            end
         end
      end
   end

endmodule

[rtl/firmware_package_checker_core.sv]
// Top level of the firmware package checker: front end, job queue, decoder, store.
// Depends on fpc_pkg, fpc_req_if, fpc_rsp_if and the fpc_* submodules.
//
// Usage:
//   req_chan carries one package byte per item; last_byte marks the final byte.
//   Bytes are taken one per cycle while the checker is between packages.
//   After the final byte, req_chan.ready stays low until the last record of
//   that package has been taken on rsp_chan; it rises at that edge.
//   rsp_chan gives 3 + DEPTH_CONFIG_SLOTS records (rgb, depth, audio, slots),
//   or one zeroed record, last_record set, for a package below header size.
//   Decoding reads the package through the store's single read port; each
//   byte read is requested and then captured. The steps are a start step,
//   the header reads, the authentication reads, the certificate kind read,
//   an emit step per header record, and per slot record its reads plus an
//   emit step. The certificate read is skipped when the certificate bounds
//   fail, the authentication and certificate reads when the authentication
//   block is out of range; a short package is not read at all.
//   A stalled rsp_chan holds the pending record; the decoder waits for it.
//   Reset clears counters, CRC, trailer and control state; the store keeps
//   its contents and needs no clearing pass.
module firmware_package_checker_core
   import fpc_pkg::*;
#(
   parameter int unsigned MAX_PACKAGE_BYTES = MAX_BYTES_DEFAULT,
   parameter int unsigned DEPTH_CONFIG_SLOTS = SLOTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   fpc_req_if.sink   req_chan,
   fpc_rsp_if.source rsp_chan
);

   localparam int unsigned ADDR_W = $clog2(MAX_PACKAGE_BYTES);

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;
   logic              job_push, job_pop, q_not_empty, back_idle, allow;
   job_type           push_job, head_job;

   assign allow = back_idle && !q_not_empty;

   fpc_front #(.MAX_PACKAGE_BYTES(MAX_PACKAGE_BYTES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .allow    (allow),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .job_push (job_push),
      .job      (push_job)
   );

   fpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .pop       (job_pop),
      .not_empty (q_not_empty),
      .head      (head_job)
   );

   fpc_store #(.MAX_PACKAGE_BYTES(MAX_PACKAGE_BYTES)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fpc_back #(
      .MAX_PACKAGE_BYTES (MAX_PACKAGE_BYTES),
      .DEPTH_CONFIG_SLOTS(DEPTH_CONFIG_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_not_empty),
      .job       (head_job),
      .job_pop   (job_pop),
      .idle      (back_idle),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rsp       (rsp_chan)
   );

`ifndef SYNTHESIS
   a_ready_only_when_empty: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> (!q_not_empty && back_idle))
      else $error("byte accepted while a package is still being decoded");

   a_no_ready_with_record: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("front end open while a record is pending");

   a_last_record_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_record) |=> !rsp_chan.valid)
      else $error("record emitted after the final record");

   a_store_idle_reads: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("store written while the decoder reads it");
`endif

endmodule
